FILE: sv/vmt_pkg.sv
// types, constants and codes shared by the vertex transform modules
package vmt_pkg;

  localparam int Dim   = 4;
  localparam int Lanes = 4;
  localparam int Cols  = 4;
  localparam int Pairs = Cols / 2;
  localparam int RowW  = $clog2(Lanes);
  localparam int ColW  = $clog2(Cols);
  localparam int RowsW = $clog2(Lanes + 1);

  typedef logic signed [31:0] q16_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [64:0] pair_t;
  typedef logic signed [65:0] sum_t;
  typedef logic signed [49:0] trunc_t;

  localparam q16_t QOne = 32'sh0001_0000;
  localparam q16_t QMax = 32'sh7FFF_FFFF;
  localparam q16_t QMin = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ModeLoad = 2'd0,
    ModeVec4 = 2'd1,
    ModeVec3 = 2'd2,
    ModeNone = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] coef_index;
    q16_t       coef_value;
    q16_t       in_x;
    q16_t       in_y;
    q16_t       in_z;
    q16_t       in_w;
  } vmt_in_t;

  typedef struct packed {
    q16_t out_x;
    q16_t out_y;
    q16_t out_z;
    q16_t out_w;
    logic overflow;
  } vmt_out_t;

  typedef struct packed {
    logic prod_en;
    logic pair_en;
    logic out_en;
  } pipe_en_t;

endpackage

FILE: sv/vmt_lane.sv
// one row lane: four products, then two pair sums
module vmt_lane import vmt_pkg::*; (
  input  logic            clk_i,
  input  pipe_en_t        en_i,
  input  q16_t            coef_i [Cols],
  input  q16_t            vec_i [Cols],
  input  logic [Cols-1:0] col_en_i,
  output pair_t           pair_o [Pairs]
);

  prod_t prod_d [Cols];
  prod_t prod_q [Cols];
  pair_t pair_d [Pairs];
  pair_t pair_q [Pairs];

  always_comb begin
    for (int c = 0; c < Cols; c++) begin
      prod_d[c] = '0;
      if (col_en_i[c]) begin
        prod_d[c] = $signed(coef_i[c]) * $signed(vec_i[c]);
      end
    end
  end

  always_comb begin
    for (int p = 0; p < Pairs; p++) begin
      pair_d[p] = pair_t'(prod_q[2*p]) + pair_t'(prod_q[2*p+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod_en) begin
      prod_q <= prod_d;
    end
    if (en_i.pair_en) begin
      pair_q <= pair_d;
    end
  end

  assign pair_o = pair_q;

endmodule

FILE: sv/vmt_merge.sv
// merging stage: final sums, truncation, saturation and overflow of all lanes
module vmt_merge import vmt_pkg::*; (
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  pair_t    pair_i [Lanes][Pairs],
  output vmt_out_t result_o
);

  sum_t     sum   [Lanes];
  trunc_t   trunc [Lanes];
  q16_t     res   [Lanes];
  logic     ovf   [Lanes];
  vmt_out_t result_d;
  vmt_out_t result_q;

  always_comb begin
    for (int r = 0; r < Lanes; r++) begin
      sum[r] = '0;
      for (int p = 0; p < Pairs; p++) begin
        sum[r] = sum[r] + sum_t'(pair_i[r][p]);
      end
      trunc[r] = $signed(sum[r][65:16]);
      res[r]   = q16_t'(trunc[r]);
      ovf[r]   = 1'b0;
      if (trunc[r] > trunc_t'(QMax)) begin
        res[r] = QMax;
        ovf[r] = 1'b1;
      end else if (trunc[r] < trunc_t'(QMin)) begin
        res[r] = QMin;
        ovf[r] = 1'b1;
      end
    end
    result_d.out_x    = res[0];
    result_d.out_y    = res[1];
    result_d.out_z    = res[2];
    result_d.out_w    = res[3];
    result_d.overflow = ovf[0] | ovf[1] | ovf[2] | ovf[3];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.out_en) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

FILE: sv/vertex_matrix_transform.sv
// top level of the vertex transform engine
// Takes one item per cycle while the output is not stalled and returns a result
// for each transform item it takes. Sixteen 32x32 signed multipliers,
// one per matrix coefficient, work in four row lanes on the same vector; a product
// stage, a pair-sum stage and a merging stage (final sum, truncation to Q16.16,
// saturation) each hold one item, so three items can be in flight. The last stage
// is the output register; while a result waits, items enter until the pipe is full.
// Coefficient loads take effect at the edge they are taken and are seen by the next
// item; loads and unused-mode items give no result.
module vertex_matrix_transform import vmt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  vmt_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output vmt_out_t out_item_o
);

  q16_t            coef_q [Lanes][Cols];
  q16_t            vec    [Cols];
  logic [Cols-1:0] col_mask;
  logic [Cols-1:0] col_en [Lanes];
  logic [RowsW-1:0] rows;
  pair_t           pair   [Lanes][Pairs];
  pipe_en_t        en;
  logic            v1_q, v2_q, v3_q;
  logic            accept, is_xform;

  assign en.out_en  = !v3_q || !out_stall_i;
  assign en.pair_en = !v2_q || en.out_en;
  assign en.prod_en = !v1_q || en.pair_en;

  assign in_stall_o = !en.prod_en;
  assign accept     = in_valid_i && en.prod_en;
  assign is_xform   = (in_item_i.mode == ModeVec4) || (in_item_i.mode == ModeVec3);

  assign rows = (in_item_i.mode == ModeVec4) ? RowsW'(Dim) : RowsW'(3);
  assign vec[0] = in_item_i.in_x;
  assign vec[1] = in_item_i.in_y;
  assign vec[2] = in_item_i.in_z;
  assign vec[3] = in_item_i.in_w;

  always_comb begin
    for (int c = 0; c < Cols; c++) begin
      col_mask[c] = (RowsW'(c) < rows);
    end
    for (int r = 0; r < Lanes; r++) begin
      col_en[r] = (RowsW'(r) < rows) ? col_mask : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Lanes; r++) begin
        for (int c = 0; c < Cols; c++) begin
          coef_q[r][c] <= (r == c) ? QOne : '0;
        end
      end
    end else if (accept && in_item_i.mode == ModeLoad) begin
      coef_q[in_item_i.coef_index[ColW+RowW-1:ColW]][in_item_i.coef_index[ColW-1:0]]
        <= in_item_i.coef_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en.prod_en) begin
        v1_q <= accept && is_xform;
      end
      if (en.pair_en) begin
        v2_q <= v1_q;
      end
      if (en.out_en) begin
        v3_q <= v2_q;
      end
    end
  end

  for (genvar r = 0; r < Lanes; r++) begin : g_lane
    vmt_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .coef_i   (coef_q[r]),
      .vec_i    (vec),
      .col_en_i (col_en[r]),
      .pair_o   (pair[r])
    );
  end

  vmt_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (en),
    .pair_i   (pair),
    .result_o (out_item_o)
  );

  assign out_valid_o = v3_q;

endmodule

FILE: sv/vmt_checker.sv
// port-level checks for the vertex transform engine, bound to the top level
module vmt_checker import vmt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input vmt_in_t  in_item_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input vmt_out_t out_item_o
);

  logic xform_accept;

  assign xform_accept = in_valid_i && !in_stall_o &&
                        (in_item_i.mode == ModeVec4 || in_item_i.mode == ModeVec3);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled output item dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled output item changed");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.overflow |->
      (out_item_o.out_x == QMax || out_item_o.out_x == QMin ||
       out_item_o.out_y == QMax || out_item_o.out_y == QMin ||
       out_item_o.out_z == QMax || out_item_o.out_z == QMin ||
       out_item_o.out_w == QMax || out_item_o.out_w == QMin))
    else $error("overflow flagged without a saturated component");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xform_accept ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("transform result missing after three cycles");

endmodule

bind vertex_matrix_transform vmt_checker u_vmt_checker (.*);
